// ----- design/bpy_pkg.sv -----
// Shared types, constants and tables of the ballistic pitch/yaw solver.
package bpy_pkg;

  localparam int XYZ_W    = 21;
  localparam int SPEED_W  = 17;
  localparam int GRAV_W   = 15;
  localparam int STATUS_W = 3;
  localparam int ANGLE_W  = 19;
  localparam int TIME_W   = 23;
  localparam int CFG_W    = 17;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ROUND_SH        = 30 - ANGLE_FRAC_BITS;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic [35:0]        ROUND_BIAS  = 36'd1 << (29 - ANGLE_FRAC_BITS);
  localparam logic signed [35:0] ANG_LIM     = 36'((HALF_PI_Q30 + ROUND_BIAS) >> ROUND_SH);

  localparam logic [TIME_W-1:0] T_SAT   = 23'd8388607;
  localparam logic [TIME_W-1:0] T_LIMIT = 23'd5000000;
  // Drop divisor 1.25e11 = 2^9 * 5^12; divide by 5^12 through floor(2^57 / 5^12)
  localparam logic [31:0]       DROP_D     = 32'd244140625;
  localparam logic [31:0]       DROP_RECIP = 32'd590295810;
  localparam logic [31:0]       US_PER_S = 32'd1000000;
  localparam logic [20:0]       MIN_RHO  = 21'd10;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_CLOSE = 3'd1,
    ST_SLOW  = 3'd2,
    ST_PITCH = 3'd3,
    ST_TIME  = 3'd4
  } status_e;

  typedef enum logic {
    CFG_SPEED = 1'b0,
    CFG_GRAV  = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_AT_INIT, S_AT_NORM, S_AT_ITER, S_AT_ROUND,
    S_MX, S_MY, S_MH, S_MR, S_SQ_INIT, S_SQ_ITER, S_SQ_DONE,
    S_MV, S_CHK, S_MT, S_TDIV, S_MG, S_ML, S_MH2, S_DDIV, S_DR, S_DQ, S_DC,
    S_DIV, S_UPD, S_FIN, S_DONE
  } state_e;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- design/bpy_if.sv -----
// Valid/ready channels for target beats and solution beats.
interface bpy_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [bpy_pkg::XYZ_W-1:0]   target_x;
  logic signed [bpy_pkg::XYZ_W-1:0]   target_y;
  logic signed [bpy_pkg::XYZ_W-1:0]   target_z;
  modport source (output valid, target_x, target_y, target_z, input ready);
  modport sink   (input valid, target_x, target_y, target_z, output ready);
endinterface

interface bpy_out_if;
  logic                                valid;
  logic                                ready;
  logic [bpy_pkg::STATUS_W-1:0]        status;
  logic signed [bpy_pkg::ANGLE_W-1:0]  yaw_angle;
  logic signed [bpy_pkg::ANGLE_W-1:0]  pitch_angle;
  logic [bpy_pkg::TIME_W-1:0]          flight_time;
  modport source (output valid, status, yaw_angle, pitch_angle, flight_time, input ready);
  modport sink   (input valid, status, yaw_angle, pitch_angle, flight_time, output ready);
endinterface

// ----- design/ballistic_pitch_yaw_solver_core.sv -----
// Ballistic solver: one shared CORDIC, square root, multiplier and divider under a sequencer.
// Yaw and range are found first; each refinement pass then runs normalize, CORDIC, square
//   root, time division, multiplies and control.
// Throughput: one target per full solve; in ready is high only while idle. A finished
//   result moves to an output register, so a new target is taken while it waits.
// Reset (rst_ni low, asynchronous) goes idle, drops any result, loads 15000 mm/s, 9800 mm/s^2.
module ballistic_pitch_yaw_solver_core #(
  parameter int ITERATIONS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bpy_in_if.sink                    in_i,
  bpy_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bpy_pkg::CFG_W-1:0] cfg_data_i
);
  import bpy_pkg::*;

  localparam int IT_W = $clog2(ITERATIONS + 1);

  state_e state_q, state_d;

  logic [SPEED_W-1:0]      speed_q;
  logic [GRAV_W-1:0]       grav_q;
  logic signed [XYZ_W-1:0] x_q, y_q, z_q;
  logic                    pitch_phase_q;
  logic signed [35:0]      cx_q, cy_q, cacc_q;
  logic [4:0]              ci_q;
  logic signed [35:0]      yaw_q, pitch_q;
  logic [63:0]             prod_q;
  logic [51:0]             sq_n_q;
  logic [27:0]             sq_rem_q;
  logic [25:0]             sq_root_q;
  logic [4:0]              sq_cnt_q;
  logic [20:0]             rho_q;
  logic signed [26:0]      h4_q;
  logic [25:0]             r4_q;
  logic [TIME_W-1:0]       t_q;
  logic [63:0]             dv_rem_q, dv_ds_q;
  logic [24:0]             dv_quo_q;
  logic [4:0]              dv_cnt_q;
  logic [37:0]             gt_q;
  logic [63:0]             lo_q;
  logic [IT_W-1:0]         iter_q;
  status_e                 status_q;
  logic                    ov_q;
  logic [STATUS_W-1:0]     o_status_q;
  logic signed [ANGLE_W-1:0] o_yaw_q, o_pitch_q;
  logic [TIME_W-1:0]       o_time_q;

  // Shared arithmetic signals
  logic [31:0]        mul_a, mul_b;
  logic [20:0]        ax, ay;
  logic [26:0]        ah4;
  logic [24:0]        rho4;
  logic signed [24:0] z4;
  logic [35:0]        acx, acy, amax;
  logic signed [35:0] dx, dy, tab;
  logic [35:0]        rmag, rnd;
  logic signed [35:0] rnd_s;
  logic [29:0]        sq_rs, sq_trial;
  logic               sq_take;
  logic               dv_take;
  logic [24:0]        dv_quo_n;
  logic               dv_last;
  logic [52:0]        dv_res;
  logic [29:0]        ten_r4;
  logic signed [27:0] zd, err;
  logic [IT_W-1:0]    iter_n;
  logic               conv;
  logic               in_acc, out_take;

  assign ax   = x_q[XYZ_W-1] ? 21'(-x_q) : 21'(x_q);
  assign ay   = y_q[XYZ_W-1] ? 21'(-y_q) : 21'(y_q);
  assign ah4  = h4_q[26] ? 27'(-h4_q) : 27'(h4_q);
  assign rho4 = {rho_q, 4'b0};
  assign z4   = $signed({z_q, 4'b0});

  assign acx  = cx_q[35] ? 36'(-cx_q) : 36'(cx_q);
  assign acy  = cy_q[35] ? 36'(-cy_q) : 36'(cy_q);
  assign amax = (acx > acy) ? acx : acy;
  assign dx   = cy_q >>> ci_q;
  assign dy   = cx_q >>> ci_q;
  assign tab  = $signed({4'b0, atan_q30(ci_q)});

  assign rmag  = cacc_q[35] ? 36'(-cacc_q) : 36'(cacc_q);
  assign rnd   = (rmag + ROUND_BIAS) >> ROUND_SH;
  assign rnd_s = cacc_q[35] ? -$signed(rnd) : $signed(rnd);

  assign sq_rs    = {sq_rem_q, sq_n_q[51:50]};
  assign sq_trial = {2'b0, sq_root_q, 2'b01};
  assign sq_take  = (sq_rs >= sq_trial);

  assign dv_take  = (dv_rem_q >= dv_ds_q);
  assign dv_quo_n = {dv_quo_q[23:0], dv_take};
  assign dv_last  = (dv_cnt_q == 5'd22);
  // Remainder after the reciprocal estimate of the drop quotient
  assign dv_res   = dv_rem_q[52:0] - prod_q[52:0];

  assign ten_r4 = {1'b0, r4_q, 3'b0} + {3'b0, r4_q, 1'b0};

  assign zd     = 28'(z4) + $signed({3'b0, dv_quo_q});
  assign err    = zd - 28'(h4_q);
  assign iter_n = iter_q + 1'b1;
  assign conv   = (err > -28'sd16) && (err < 28'sd16);

  assign in_acc   = in_i.valid && (state_q == S_IDLE);
  assign out_take = (state_q == S_DONE) && (!ov_q || out_o.ready);

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MX:    begin mul_a = 32'(ax);           mul_b = 32'(ax);     end
      S_MY:    begin mul_a = 32'(ay);           mul_b = 32'(ay);     end
      S_MH:    begin mul_a = 32'(ah4);          mul_b = 32'(ah4);    end
      S_MR:    begin mul_a = 32'(rho4);         mul_b = 32'(rho4);   end
      S_MV:    begin mul_a = 32'(speed_q);      mul_b = 32'(rho4);   end
      S_MT:    begin mul_a = 32'(r4_q);         mul_b = US_PER_S;    end
      S_MG:    begin mul_a = 32'(grav_q);       mul_b = 32'(t_q);    end
      S_ML:    begin mul_a = prod_q[31:0];      mul_b = 32'(t_q);    end
      S_MH2:   begin mul_a = 32'(gt_q[37:32]);  mul_b = 32'(t_q);    end
      S_DR:    begin mul_a = dv_rem_q[51:20];   mul_b = DROP_RECIP;  end
      S_DQ:    begin mul_a = 32'(prod_q[61:37]); mul_b = DROP_D;     end
      default: begin mul_a = '0;                mul_b = '0;          end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_i.valid) state_d = S_AT_INIT;
      S_AT_INIT:  state_d = (cx_q == '0 && cy_q == '0) ? S_AT_ROUND : S_AT_NORM;
      S_AT_NORM:  if (amax >= 36'h40000000) state_d = S_AT_ITER;
      S_AT_ITER:  if (ci_q == 5'd31) state_d = S_AT_ROUND;
      S_AT_ROUND: state_d = pitch_phase_q ? S_MH : S_MX;
      S_MX:       state_d = S_MY;
      S_MY:       state_d = S_SQ_INIT;
      S_MH:       state_d = S_MR;
      S_MR:       state_d = S_SQ_INIT;
      S_SQ_INIT:  state_d = S_SQ_ITER;
      S_SQ_ITER:  if (sq_cnt_q == 5'd25) state_d = S_SQ_DONE;
      S_SQ_DONE: begin
        if (pitch_phase_q) state_d = S_MV;
        else if (sq_root_q[20:0] < MIN_RHO) state_d = S_DONE;
        else state_d = S_AT_INIT;
      end
      S_MV:       state_d = S_CHK;
      S_CHK:      state_d = (prod_q < 64'(ten_r4)) ? S_DONE : S_MT;
      S_MT:       state_d = S_TDIV;
      S_TDIV:     state_d = (prod_q >= (64'(speed_q) << 27)) ? S_MG : S_DIV;
      S_MG:       state_d = S_ML;
      S_ML:       state_d = S_MH2;
      S_MH2:      state_d = S_DDIV;
      S_DDIV:     state_d = S_DR;
      S_DR:       state_d = S_DQ;
      S_DQ:       state_d = S_DC;
      S_DC:       state_d = S_UPD;
      S_DIV:      if (dv_last) state_d = S_MG;
      S_UPD:      state_d = (conv || iter_n == IT_W'(ITERATIONS)) ? S_FIN : S_AT_INIT;
      S_FIN:      state_d = S_DONE;
      S_DONE:     if (out_take) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Handshake and payload outputs
  always_comb begin
    in_i.ready        = (state_q == S_IDLE);
    out_o.valid       = ov_q;
    out_o.status      = o_status_q;
    out_o.yaw_angle   = o_yaw_q;
    out_o.pitch_angle = o_pitch_q;
    out_o.flight_time = o_time_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      speed_q <= 17'd15000;
      grav_q  <= 15'd9800;
    end else begin
      state_q <= state_d;
      if (out_take) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SPEED: speed_q <= cfg_data_i[SPEED_W-1:0];
          CFG_GRAV:  grav_q  <= cfg_data_i[GRAV_W-1:0];
          default:   ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    prod_q <= {32'b0, mul_a} * {32'b0, mul_b};
    case (state_q)
      S_IDLE: if (in_acc) begin
        x_q           <= in_i.target_x;
        y_q           <= in_i.target_y;
        z_q           <= in_i.target_z;
        cx_q          <= 36'(in_i.target_x);
        cy_q          <= 36'(in_i.target_y);
        pitch_phase_q <= 1'b0;
        pitch_q       <= '0;
        t_q           <= '0;
        iter_q        <= '0;
        status_q      <= ST_OK;
      end
      S_AT_INIT: begin
        ci_q <= '0;
        if (cx_q < 0) begin
          cacc_q <= (cy_q >= 0) ? PI_Q30 : -PI_Q30;
          cx_q   <= -cx_q;
          cy_q   <= -cy_q;
        end else begin
          cacc_q <= '0;
        end
      end
      S_AT_NORM: if (amax < 36'h40000000) begin
        cx_q <= cx_q <<< 1;
        cy_q <= cy_q <<< 1;
      end
      S_AT_ITER: begin
        ci_q <= ci_q + 5'd1;
        if (cy_q > 0) begin
          cx_q   <= cx_q + dx;
          cy_q   <= cy_q - dy;
          cacc_q <= cacc_q + tab;
        end else begin
          cx_q   <= cx_q - dx;
          cy_q   <= cy_q + dy;
          cacc_q <= cacc_q - tab;
        end
      end
      S_AT_ROUND: begin
        if (pitch_phase_q) pitch_q <= rnd_s;
        else yaw_q <= rnd_s;
      end
      S_MY, S_MR: sq_n_q <= prod_q[51:0];
      S_SQ_INIT: begin
        sq_n_q    <= sq_n_q + prod_q[51:0];
        sq_rem_q  <= '0;
        sq_root_q <= '0;
        sq_cnt_q  <= '0;
      end
      S_SQ_ITER: begin
        sq_n_q   <= {sq_n_q[49:0], 2'b00};
        sq_cnt_q <= sq_cnt_q + 5'd1;
        if (sq_take) begin
          sq_rem_q  <= 28'(sq_rs - sq_trial);
          sq_root_q <= {sq_root_q[24:0], 1'b1};
        end else begin
          sq_rem_q  <= sq_rs[27:0];
          sq_root_q <= {sq_root_q[24:0], 1'b0};
        end
      end
      S_SQ_DONE: begin
        if (pitch_phase_q) begin
          r4_q <= sq_root_q;
        end else if (sq_root_q[20:0] < MIN_RHO) begin
          status_q <= ST_CLOSE;
        end else begin
          rho_q         <= sq_root_q[20:0];
          h4_q          <= 27'(z4);
          cx_q          <= $signed({11'b0, sq_root_q[20:0], 4'b0});
          cy_q          <= 36'(z4);
          pitch_phase_q <= 1'b1;
        end
      end
      S_CHK: if (prod_q < 64'(ten_r4)) status_q <= ST_SLOW;
      S_TDIV: begin
        if (prod_q >= (64'(speed_q) << 27)) begin
          t_q <= T_SAT;
        end else begin
          dv_rem_q  <= prod_q;
          dv_ds_q   <= 64'(speed_q) << 26;
          dv_quo_q  <= '0;
          dv_cnt_q  <= '0;
        end
      end
      S_ML:  gt_q <= prod_q[37:0];
      S_MH2: lo_q <= prod_q;
      // Drop the 2^9 factor of the divisor, keep the rest for the reciprocal
      S_DDIV: dv_rem_q <= (lo_q + {prod_q[31:0], 32'b0}) >> 9;
      S_DQ:   dv_quo_q <= prod_q[61:37];
      // The estimate is low by at most one
      S_DC:   if (dv_res >= 53'(DROP_D)) dv_quo_q <= dv_quo_q + 25'd1;
      S_DIV: begin
        if (dv_take) dv_rem_q <= dv_rem_q - dv_ds_q;
        dv_ds_q  <= dv_ds_q >> 1;
        dv_quo_q <= dv_quo_n;
        dv_cnt_q <= dv_cnt_q + 5'd1;
        if (dv_last) t_q <= dv_quo_n[TIME_W-1:0];
      end
      S_UPD: begin
        h4_q   <= zd[26:0];
        iter_q <= iter_n;
        cx_q   <= $signed({11'b0, rho4});
        cy_q   <= 36'(zd);
      end
      S_FIN: if (status_q == ST_OK) begin
        if (pitch_q > ANG_LIM || pitch_q < -ANG_LIM) status_q <= ST_PITCH;
        else if (t_q > T_LIMIT) status_q <= ST_TIME;
      end
      S_DONE: if (out_take) begin
        o_status_q <= status_q;
        o_yaw_q    <= yaw_q[ANGLE_W-1:0];
        o_pitch_q  <= pitch_q[ANGLE_W-1:0];
        o_time_q   <= t_q;
      end
      default: ;
    endcase
  end

endmodule

// ----- design/bpy_checker.sv -----
// Port-level checks of the ballistic solver, bound to the top level.
module bpy_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bpy_pkg::STATUS_W-1:0]  out_status,
  input logic [bpy_pkg::ANGLE_W-1:0]   out_pitch,
  input logic [bpy_pkg::TIME_W-1:0]    out_time
);
  import bpy_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_time))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("target beat taken while solving");

  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status == STATUS_W'(ST_CLOSE) |-> out_pitch == '0 && out_time == '0)
    else $error("too-close result carries pitch or time");

  a_ok_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status == STATUS_W'(ST_OK) |-> out_time <= T_LIMIT)
    else $error("ok result with flight time beyond limit");

endmodule

bind ballistic_pitch_yaw_solver_core bpy_checker u_bpy_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_status (out_o.status),
  .out_pitch  (out_o.pitch_angle),
  .out_time   (out_o.flight_time)
);
